// ----- hdl/mrdc_pkg.sv -----
// Package with the types, codes and reset values of the motor ramp drive controller.
`timescale 1ns / 1ps

package mrdc_pkg;

    localparam int unsigned SPEED_W = 8;
    localparam int unsigned DELAY_W = 5;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 16;

    localparam logic [SPEED_W-1:0] MAX_SPEED_RST      = 8'd100;
    localparam logic [SPEED_W-1:0] MIN_SPEED_RST      = 8'd20;
    localparam logic [SPEED_W-1:0] STEP_UP_RST        = 8'd1;
    localparam logic [SPEED_W-1:0] STEP_DOWN_RST      = 8'd8;
    localparam logic [SPEED_W-1:0] STEP_DOWN_IDLE_RST = 8'd1;
    localparam logic [SPEED_W-1:0] STEERING_SPEED_RST = 8'd20;
    localparam logic [DELAY_W-1:0] DIRECTION_DELAY_RST = DELAY_W'(350 / 20);

    typedef enum logic [6:0] {
        MODE_ACCEL   = 7'b0000001,
        MODE_DECEL   = 7'b0000010,
        MODE_STEER_L = 7'b0000100,
        MODE_BRAKE_L = 7'b0001000,
        MODE_STEER_R = 7'b0010000,
        MODE_BRAKE_R = 7'b0100000,
        MODE_IDLE    = 7'b1000000
    } mode_t;

    typedef enum logic [CODE_W-1:0] {
        CODE_ACCEL   = 3'd0,
        CODE_DECEL   = 3'd1,
        CODE_STEER_L = 3'd2,
        CODE_BRAKE_L = 3'd3,
        CODE_STEER_R = 3'd4,
        CODE_BRAKE_R = 3'd5,
        CODE_IDLE    = 3'd6
    } mode_code_t;

    typedef enum logic [2:0] {
        REQ_ACCEL = 3'd0,
        REQ_DECEL = 3'd1,
        REQ_LEFT  = 3'd2,
        REQ_RIGHT = 3'd3,
        REQ_IDLE  = 3'd4
    } req_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_SPEED       = 3'd0,
        CFG_MIN_SPEED       = 3'd1,
        CFG_STEP_UP         = 3'd2,
        CFG_STEP_DOWN       = 3'd3,
        CFG_STEP_DOWN_IDLE  = 3'd4,
        CFG_STEERING_SPEED  = 3'd5,
        CFG_DIRECTION_DELAY = 3'd6
    } cfg_index_t;

    // Bridge levels, right A in the top bit down to left B in the bottom bit.
    localparam logic [3:0] PINS_FORWARD  = 4'b0101;
    localparam logic [3:0] PINS_BACKWARD = 4'b1010;
    localparam logic [3:0] PINS_STEER_L  = 4'b0110;
    localparam logic [3:0] PINS_BRAKE_L  = 4'b0111;
    localparam logic [3:0] PINS_STEER_R  = 4'b1001;
    localparam logic [3:0] PINS_BRAKE_R  = 4'b1101;

    function automatic mode_code_t mode_code(input mode_t mode);
        mode_code_t code;
        unique case (mode)
            MODE_ACCEL:   code = CODE_ACCEL;
            MODE_DECEL:   code = CODE_DECEL;
            MODE_STEER_L: code = CODE_STEER_L;
            MODE_BRAKE_L: code = CODE_BRAKE_L;
            MODE_STEER_R: code = CODE_STEER_R;
            MODE_BRAKE_R: code = CODE_BRAKE_R;
            default:      code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ----- hdl/motor_ramp_drive_controller.sv -----
// Top level of the motor ramp drive controller: request decode, drive state machine and duty ramp.
`timescale 1ns / 1ps

// One button transaction is one control tick. A tick is accepted whenever s_tready is high; its
// result goes to the result register, or to the skid register while that one waits. Throughput is
// one transaction per cycle while s_tready is high, set by the single register stage that holds
// the drive state, the duty and the direction. A two-entry output buffer (result register plus skid
// register) lets the slave side keep accepting while one result waits; s_tready falls only when
// both entries are full. Configuration writes are always ready and take effect on the next tick.
module motor_ramp_drive_controller
    import mrdc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [0] button_up, [1] button_left, [2] button_right, [3] button_down, [7:4] zero
    input  logic [S_TDATA_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] right_pin_a, [1] right_pin_b, [2] left_pin_a, [3] left_pin_b, [11:4] duty,
    // [12] direction, [15:13] drive_mode
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [SPEED_W-1:0] max_speed_reg;
    logic [SPEED_W-1:0] min_speed_reg;
    logic [SPEED_W-1:0] step_up_reg;
    logic [SPEED_W-1:0] step_down_reg;
    logic [SPEED_W-1:0] step_down_idle_reg;
    logic [SPEED_W-1:0] steering_speed_reg;
    logic [DELAY_W-1:0] direction_delay_reg;

    mode_t              mode_reg, mode_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic               direction_reg, direction_next;
    logic [DELAY_W-1:0] counter_reg, counter_next;

    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic [M_TDATA_W-1:0] skid_data_reg, skid_data_next;

    req_t                 req;
    logic [3:0]           pins;
    logic [M_TDATA_W-1:0] result;
    logic                 s_accept;
    logic                 m_take;
    logic [DELAY_W-1:0]   counter_load;

    function automatic logic [SPEED_W-1:0] ramp_up(
        input logic [SPEED_W-1:0] s,
        input logic [SPEED_W-1:0] step,
        input logic [SPEED_W-1:0] max_s,
        input logic [SPEED_W-1:0] min_s
    );
        logic [SPEED_W:0]   sum;
        logic [SPEED_W-1:0] r;
        sum = {1'b0, s} + {1'b0, step};
        if (sum > {1'b0, max_s}) begin
            r = max_s;
        end else if (s < min_s) begin
            r = min_s;
        end else begin
            r = sum[SPEED_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [SPEED_W-1:0] ramp_down(
        input logic [SPEED_W-1:0] s,
        input logic [SPEED_W-1:0] step,
        input logic [SPEED_W-1:0] min_s
    );
        logic [SPEED_W-1:0] r;
        if (s <= min_s) begin
            r = '0;
        end else if (s > step) begin
            r = s - step;
        end else begin
            r = '0;
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_take    = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg       <= MAX_SPEED_RST;
            min_speed_reg       <= MIN_SPEED_RST;
            step_up_reg         <= STEP_UP_RST;
            step_down_reg       <= STEP_DOWN_RST;
            step_down_idle_reg  <= STEP_DOWN_IDLE_RST;
            steering_speed_reg  <= STEERING_SPEED_RST;
            direction_delay_reg <= DIRECTION_DELAY_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MAX_SPEED:       max_speed_reg       <= cfg_data;
                CFG_MIN_SPEED:       min_speed_reg       <= cfg_data;
                CFG_STEP_UP:         step_up_reg         <= cfg_data;
                CFG_STEP_DOWN:       step_down_reg       <= cfg_data;
                CFG_STEP_DOWN_IDLE:  step_down_idle_reg  <= cfg_data;
                CFG_STEERING_SPEED:  steering_speed_reg  <= cfg_data;
                CFG_DIRECTION_DELAY: direction_delay_reg <= cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (s_tdata[0]) begin
            req = REQ_ACCEL;
        end else if (s_tdata[1]) begin
            req = REQ_LEFT;
        end else if (s_tdata[2]) begin
            req = REQ_RIGHT;
        end else if (s_tdata[3]) begin
            req = REQ_DECEL;
        end else begin
            req = REQ_IDLE;
        end
    end

    always_comb begin
        unique case (req)
            REQ_ACCEL: mode_next = MODE_ACCEL;
            REQ_DECEL: mode_next = MODE_DECEL;
            REQ_LEFT: begin
                mode_next = (mode_reg == MODE_STEER_L || mode_reg == MODE_BRAKE_L)
                          ? MODE_STEER_L : MODE_BRAKE_L;
            end
            REQ_RIGHT: begin
                mode_next = (mode_reg == MODE_STEER_R || mode_reg == MODE_BRAKE_R)
                          ? MODE_STEER_R : MODE_BRAKE_R;
            end
            default: mode_next = MODE_IDLE;
        endcase
    end

    // Direction may only be set at standstill, and only once the reversal counter has run out.
    always_comb begin
        direction_next = direction_reg;
        counter_load   = counter_reg;
        counter_next   = counter_reg;
        if (speed_reg == '0 && (req == REQ_ACCEL || req == REQ_DECEL)) begin
            if (counter_reg == '0) begin
                direction_next = (req == REQ_DECEL);
                counter_load   = direction_delay_reg;
            end
            counter_next = counter_load - DELAY_W'(1);
        end
    end

    always_comb begin
        unique case (mode_next)
            MODE_ACCEL: begin
                speed_next = direction_next
                    ? ramp_down(speed_reg, step_down_reg, min_speed_reg)
                    : ramp_up(speed_reg, step_up_reg, max_speed_reg, min_speed_reg);
            end
            MODE_DECEL: begin
                speed_next = direction_next
                    ? ramp_up(speed_reg, step_up_reg, max_speed_reg, min_speed_reg)
                    : ramp_down(speed_reg, step_down_reg, min_speed_reg);
            end
            MODE_IDLE:    speed_next = ramp_down(speed_reg, step_down_idle_reg, min_speed_reg);
            MODE_STEER_L: speed_next = steering_speed_reg;
            MODE_STEER_R: speed_next = steering_speed_reg;
            default:      speed_next = speed_reg;
        endcase
    end

    always_comb begin
        unique case (mode_next)
            MODE_STEER_L: pins = PINS_STEER_L;
            MODE_BRAKE_L: pins = PINS_BRAKE_L;
            MODE_STEER_R: pins = PINS_STEER_R;
            MODE_BRAKE_R: pins = PINS_BRAKE_R;
            default:      pins = direction_next ? PINS_BACKWARD : PINS_FORWARD;
        endcase
        result = {mode_code(mode_next), direction_next, speed_next,
                  pins[0], pins[1], pins[2], pins[3]};
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_take) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (s_accept) begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (s_accept) begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            speed_reg      <= '0;
            direction_reg  <= 1'b0;
            counter_reg    <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                mode_reg      <= mode_next;
                speed_reg     <= speed_next;
                direction_reg <= direction_next;
                counter_reg   <= counter_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef SYNTH
    a_skid_behind_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    a_direction_at_standstill: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && direction_reg != $past(direction_reg))
            |-> ($past(s_accept) && $past(speed_reg) == '0))
        else $error("direction changed while moving or without a transaction");

    a_counter_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && counter_reg != $past(counter_reg)) |-> $past(s_accept))
        else $error("reversal counter changed without a transaction");
`endif

endmodule
